// ----- hw/rtl/assert_macros.svh -----
// assertion helpers shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is held
`define FRM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that is checked during reset too
`define FRM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/frm_pkg.sv -----
package frm_pkg;

  // field widths
  localparam int unsigned TS_W     = 32;
  localparam int unsigned TPS_W    = 20;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned RATE_W   = 28;
  localparam int unsigned DVD_W    = TPS_W + FRAC_W;

  // averaging window
  localparam int unsigned WIN_LOG2 = 6;
  localparam int unsigned DEPTH    = 1 << WIN_LOG2;
  localparam int unsigned SUM_W    = RATE_W + WIN_LOG2;

  // divider step count, one quotient bit per cycle
  localparam int unsigned DIV_STEPS = DVD_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(1000);

  // ring control from the sequencer
  typedef struct packed {
    logic rd;
    logic sub;
    logic add;
  } ring_ctl_t;

endpackage

// ----- hw/rtl/frm_div.sv -----
`include "assert_macros.svh"

module frm_div
  import frm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DVD_W-1:0]  dividend_i,
  input  logic [TS_W-1:0]   divisor_i,
  output logic              busy_o,
  output logic [RATE_W-1:0] quotient_o
);

  localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_STEPS - 1);

  logic              busy_q, busy_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DVD_W-1:0]  shq_q, shq_d;
  logic [TS_W-1:0]   rem_q, rem_d;
  logic [TS_W-1:0]   dvs_q, dvs_d;
  logic [TS_W:0]     rem_sh;
  logic [TS_W:0]     diff;

  // one restoring step: shift in the next dividend bit, try the subtract
  assign rem_sh = {rem_q, shq_q[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    shq_d  = shq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      shq_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // quotient bits enter at the bottom as the dividend leaves the top
      if (!diff[TS_W]) begin
        rem_d = diff[TS_W-1:0];
        shq_d = {shq_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[TS_W-1:0];
        shq_d = {shq_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk_i) begin
    shq_q <= shq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = shq_q[RATE_W-1:0];

  `FRM_ASSERT(a_start_busy, clk_i, rst_ni, start_i |=> busy_q, "divider not busy after start")
  `FRM_ASSERT(a_last_step, clk_i, rst_ni, busy_q && !start_i && cnt_q == LAST |=> !busy_q,
              "divider ran past its last step")
  `FRM_ASSERT(a_rem_bound, clk_i, rst_ni, busy_q && !start_i |=> rem_q < dvs_q,
              "partial remainder not below divisor")

endmodule

// ----- hw/rtl/frm_ring.sv -----
`include "assert_macros.svh"

module frm_ring
  import frm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ring_ctl_t         ctl_i,
  input  logic [RATE_W-1:0] rate_i,
  output logic [RATE_W-1:0] average_o
);

  logic [RATE_W-1:0]   mem [DEPTH];
  logic [DEPTH-1:0]    vld_q;
  logic [WIN_LOG2-1:0] idx_q;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [RATE_W-1:0]   old_q;
  logic                old_vld_q;
  logic [RATE_W-1:0]   old_val;

  // registered read of the slot about to be replaced
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) begin
      old_q <= mem[idx_q];
    end
    if (ctl_i.sub) begin
      mem[idx_q] <= rate_i;
    end
  end

  // an entry never written since reset reads as zero
  assign old_val = old_vld_q ? old_q : '0;

  always_comb begin
    sum_d = sum_q;
    if (ctl_i.sub) begin
      sum_d = sum_q - SUM_W'(old_val);
    end else if (ctl_i.add) begin
      sum_d = sum_q + SUM_W'(rate_i);
    end
  end

  // valid bits, index and running sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      idx_q     <= '0;
      sum_q     <= '0;
      old_vld_q <= 1'b0;
    end else begin
      sum_q <= sum_d;
      if (ctl_i.rd) begin
        old_vld_q <= vld_q[idx_q];
      end
      if (ctl_i.sub) begin
        vld_q[idx_q] <= 1'b1;
      end
      if (ctl_i.add) begin
        idx_q <= idx_q + WIN_LOG2'(1);
      end
    end
  end

  assign average_o = sum_q[SUM_W-1:WIN_LOG2];

  `FRM_ASSERT(a_idx_step, clk_i, rst_ni, ctl_i.add |=> idx_q == $past(idx_q + WIN_LOG2'(1)),
              "ring index did not advance")
  `FRM_ASSERT(a_idx_hold, clk_i, rst_ni, !ctl_i.add |=> idx_q == $past(idx_q),
              "ring index moved without an update")
  `FRM_ASSERT(a_one_op, clk_i, rst_ni, !(ctl_i.sub && ctl_i.add),
              "subtract and add requested together")

endmodule

// ----- hw/rtl/frame_rate_moving_average_top.sv -----
// channel   | direction | handshake                   | payload
// input     | in        | in_valid_i / in_stall_o     | timestamp_i
// output    | out       | out_valid_o / out_stall_i   | average_rate_o, instant_rate_o
// config    | in        | cfg_valid_i / cfg_ready_o   | cfg_data_i (ticks_per_second)
//
// after acceptance a request takes one radix-2 divider step per cycle for 28 quotient bits,
// then a ring subtract, a ring add and the load
// the divider loop sets the rate; the next request is taken once the result is loaded
// the result register holds while out_stall_i is high, and a new request is still
// accepted then; the sequencer waits in its final state only if that register is full
// reset is asynchronous, active low; the ring is marked empty at once, no clearing pass
`include "assert_macros.svh"

module frame_rate_moving_average_top
  import frm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [TS_W-1:0]   timestamp_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [RATE_W-1:0] average_rate_o,
  output logic [RATE_W-1:0] instant_rate_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [TPS_W-1:0]  cfg_data_i
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_SUB  = 5'b00100,
    ST_ADD  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [TPS_W-1:0]  tps_q;
  logic [TS_W-1:0]   prev_q;
  logic [TS_W-1:0]   diff;
  logic [TS_W-1:0]   interval;
  logic              accept;
  logic              div_busy;
  logic [RATE_W-1:0] quotient;
  logic [RATE_W-1:0] average;
  ring_ctl_t         ring_ctl;
  logic              load;
  logic              out_valid_q, out_valid_d;
  logic [RATE_W-1:0] avg_q, inst_q;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // elapsed ticks, a repeated timestamp counts as one tick
  assign diff     = timestamp_i - prev_q;
  assign interval = (diff == '0) ? TS_W'(1) : diff;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_DIV;
      ST_DIV:  if (!div_busy) state_d = ST_SUB;
      ST_SUB:  state_d = ST_ADD;
      ST_ADD:  state_d = ST_DONE;
      ST_DONE: if (load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign ring_ctl.rd  = accept;
  assign ring_ctl.sub = (state_q == ST_SUB);
  assign ring_ctl.add = (state_q == ST_ADD);

  // result register loads in the done state when empty or being taken
  assign load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state, config register and previous timestamp
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      tps_q       <= TPS_RESET;
      prev_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tps_q <= cfg_data_i;
      end
      if (accept) begin
        prev_q <= timestamp_i;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      avg_q  <= average;
      inst_q <= quotient;
    end
  end

  frm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i ({tps_q, {FRAC_W{1'b0}}}),
    .divisor_i  (interval),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  frm_ring u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ring_ctl),
    .rate_i    (quotient),
    .average_o (average)
  );

  assign out_valid_o    = out_valid_q;
  assign average_rate_o = avg_q;
  assign instant_rate_o = inst_q;

  `FRM_ASSERT(a_accept_div, clk_i, rst_ni, accept |=> state_q == ST_DIV && div_busy,
              "request accepted but divider not started")
  `FRM_ASSERT(a_sub_after_div, clk_i, rst_ni, state_q == ST_SUB |-> !div_busy,
              "ring update while divider still busy")
  `FRM_ASSERT(a_rise_from_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == ST_DONE),
              "result appeared without a finished request")

endmodule

// ----- tb/sv/tb_frame_rate_moving_average_top.sv -----
module tb_frame_rate_moving_average_top;
  import frm_pkg::*;

  localparam logic [RATE_W-1:0] RATE_SAT = {RATE_W{1'b1}};

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [TS_W-1:0]   value;
    logic              fixed;
    logic [RATE_W-1:0] avg;
    logic [RATE_W-1:0] inst;
  } stim_row_t;

  typedef struct packed {
    logic [RATE_W-1:0] avg;
    logic [RATE_W-1:0] inst;
  } rate_pair_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [TS_W-1:0]   timestamp_i;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [RATE_W-1:0] average_rate_o;
  logic [RATE_W-1:0] instant_rate_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [TPS_W-1:0]  cfg_data_i;

  // rate meter state as the block should hold it
  logic [TPS_W-1:0]  m_tps;
  logic [TS_W-1:0]   m_prev_time;
  logic [RATE_W-1:0] m_ring [DEPTH];
  logic [WIN_LOG2-1:0] m_slot;
  logic [SUM_W-1:0]  m_sum;

  rate_pair_t  rate_expect_q [$];
  int unsigned mismatch_count = 0;
  bit          idle_enabled   = 1'b1;
  int unsigned stall_left     = 0;
  logic [TS_W-1:0] last_ts;

  // expected values typed in where they follow directly from the reset state
  stim_row_t directed_rows [22] = '{
    '{ROW_ITEM, 32'd1000,       1'b1, 28'd4,       28'd256},
    '{ROW_ITEM, 32'd1000,       1'b1, 28'd4004,    28'd256000},
    '{ROW_ITEM, 32'd0,          1'b1, 28'd4004,    28'd0},
    '{ROW_ITEM, 32'hFFFF_FFFF,  1'b1, 28'd4004,    28'd0},
    '{ROW_ITEM, 32'd0,          1'b1, 28'd8004,    28'd256000},
    '{ROW_CFG,  32'h000F_FFFF,  1'b0, 28'd0,       28'd0},
    '{ROW_ITEM, 32'd1,          1'b1, 28'd4202304, 28'hFFF_FF00},
    '{ROW_ITEM, 32'd1,          1'b0, 28'd0,       28'd0},
    '{ROW_ITEM, 32'd2,          1'b0, 28'd0,       28'd0},
    '{ROW_CFG,  32'd0,          1'b0, 28'd0,       28'd0},
    '{ROW_ITEM, 32'd5000,       1'b0, 28'd0,       28'd0},
    '{ROW_ITEM, 32'd5000,       1'b0, 28'd0,       28'd0},
    '{ROW_CFG,  32'd1,          1'b0, 28'd0,       28'd0},
    '{ROW_ITEM, 32'd5001,       1'b0, 28'd0,       28'd0},
    '{ROW_ITEM, 32'd5257,       1'b0, 28'd0,       28'd0},
    '{ROW_ITEM, 32'd5514,       1'b0, 28'd0,       28'd0},
    '{ROW_CFG,  32'd1000000,    1'b0, 28'd0,       28'd0},
    '{ROW_ITEM, 32'h8000_0000,  1'b0, 28'd0,       28'd0},
    '{ROW_ITEM, 32'h8000_411B,  1'b0, 28'd0,       28'd0},
    '{ROW_ITEM, 32'h7FFF_FFFF,  1'b0, 28'd0,       28'd0},
    '{ROW_ITEM, 32'h8000_0000,  1'b0, 28'd0,       28'd0},
    '{ROW_CFG,  32'd1000,       1'b0, 28'd0,       28'd0}
  };

  frame_rate_moving_average_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .timestamp_i    (timestamp_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .average_rate_o (average_rate_o),
    .instant_rate_o (instant_rate_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // instant rate from the interval, then the ring and running sum update
  function automatic rate_pair_t predict_rates(input logic [TS_W-1:0] ts);
    logic [TS_W-1:0] interval;
    logic [63:0]     quotient;
    rate_pair_t      r;
    interval = ts - m_prev_time;
    if (interval == '0) interval = TS_W'(1);
    quotient = 64'({m_tps, 8'h00}) / 64'(interval);
    r.inst = (quotient > 64'(RATE_SAT)) ? RATE_SAT : quotient[RATE_W-1:0];
    m_sum = m_sum - SUM_W'(m_ring[m_slot]) + SUM_W'(r.inst);
    m_ring[m_slot] = r.inst;
    m_slot = m_slot + WIN_LOG2'(1);
    m_prev_time = ts;
    r.avg = m_sum[SUM_W-1:WIN_LOG2];
    return r;
  endfunction

  // mix of frame-like intervals, repeats, wraps and arbitrary jumps
  function automatic logic [TS_W-1:0] pick_timestamp(input logic [TS_W-1:0] last);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return last;
    if (sel < 50) return last + $urandom_range(1, 64);
    if (sel < 80) return last + $urandom_range(65, 100000);
    if (sel < 90) return last + $urandom;
    return $urandom;
  endfunction

  task automatic report_mismatch(input string what, input logic [RATE_W-1:0] got,
                                 input logic [RATE_W-1:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // random sender gap, entered and left at a falling edge
  task automatic sender_gap();
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
  endtask

  // one request; expectation is queued at the edge that accepts it
  task automatic send_request(input logic [TS_W-1:0] ts, input logic fixed,
                              input logic [RATE_W-1:0] avg, input logic [RATE_W-1:0] inst);
    rate_pair_t predicted;
    in_valid_i  <= 1'b1;
    timestamp_i <= ts;
    do @(posedge clk_i); while (in_stall_o);
    predicted = predict_rates(ts);
    if (fixed) begin
      predicted.avg  = avg;
      predicted.inst = inst;
    end
    rate_expect_q.insert(rate_expect_q.size(), predicted);
    last_ts = ts;
    @(negedge clk_i);
  endtask

  // wait for every result, then write ticks_per_second
  task automatic drain_then_config(input logic [TPS_W-1:0] tps);
    in_valid_i <= 1'b0;
    while (rate_expect_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= tps;
    do @(posedge clk_i); while (!cfg_ready_o);
    m_tps = tps;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // receiver stall bursts of random length
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
      stall_left  <= $urandom_range(0, 16);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    rate_pair_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (rate_expect_q.size() == 0) begin
        report_mismatch("unexpected result", average_rate_o, '0);
      end else begin
        want = rate_expect_q.pop_front();
        if (average_rate_o !== want.avg) report_mismatch("average_rate", average_rate_o, want.avg);
        if (instant_rate_o !== want.inst) report_mismatch("instant_rate", instant_rate_o, want.inst);
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [TPS_W-1:0] phase_tps [6];
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    timestamp_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    m_tps       = TPS_RESET;
    m_prev_time = '0;
    m_slot      = '0;
    m_sum       = '0;
    last_ts     = '0;
    foreach (m_ring[i]) m_ring[i] = '0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed rows
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        drain_then_config(directed_rows[i].value[TPS_W-1:0]);
      end else begin
        sender_gap();
        send_request(directed_rows[i].value, directed_rows[i].fixed,
                     directed_rows[i].avg, directed_rows[i].inst);
      end
    end

    // random phases over several tick rates, last one without idling
    phase_tps[0] = TPS_W'($urandom_range(1, 1000000));
    phase_tps[1] = TPS_W'(1);
    phase_tps[2] = TPS_W'(1000000);
    phase_tps[3] = {TPS_W{1'b1}};
    phase_tps[4] = TPS_W'($urandom_range(1, 5000));
    phase_tps[5] = TPS_RESET;
    for (int p = 0; p < 6; p++) begin
      drain_then_config(phase_tps[p]);
      if (p == 5) idle_enabled = 1'b0;
      for (int n = 0; n < 125; n++) begin
        sender_gap();
        send_request(pick_timestamp(last_ts), 1'b0, '0, '0);
      end
    end

    // drain and settle
    in_valid_i <= 1'b0;
    while (rate_expect_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/frm_pkg.sv
hw/rtl/frm_div.sv
hw/rtl/frm_ring.sv
hw/rtl/frame_rate_moving_average_top.sv
tb/sv/tb_frame_rate_moving_average_top.sv
